@@ rtl/core/grain_growth_phase_field_update_defines.svh @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - assertion macros
// Shared concurrent assertion helpers for the RTL modules.
// ----------------------------------------------------------------------------
`ifndef GRAIN_GROWTH_PHASE_FIELD_UPDATE_DEFINES_SVH
`define GRAIN_GROWTH_PHASE_FIELD_UPDATE_DEFINES_SVH

// same-cycle implication
`define GGPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GGPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ggpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - package
// Payload types, run descriptor, divider interface and Q8.24 helpers.
// ----------------------------------------------------------------------------
package ggpf_pkg;

   localparam int SUM_W  = 38;
   localparam int IDX_W  = 6;
   localparam int QUOT_W = 32;
   localparam int NUM_W  = SUM_W + 24;

   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
   localparam logic signed [63:0] Q_RND = 64'sd8388608;

   typedef struct packed {
      logic signed [31:0] order_value;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_z;
      logic [30:0]        grain_energy;
      logic               last_grain;
   } req_type;

   typedef struct packed {
      logic               term_kind;
      logic [5:0]         grain_index;
      logic signed [31:0] value_term;
      logic signed [31:0] out_grad_x;
      logic signed [31:0] out_grad_y;
      logic signed [31:0] out_grad_z;
      logic               divide_fault;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] n;
      logic [2:0][31:0]   grad;
      logic [30:0]        rho;
   } grain_type;

   typedef struct packed {
      logic [IDX_W-1:0] count;
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] w;
   } run_type;

   typedef struct packed {
      logic [30:0] alpha;
      logic [30:0] m0;
      logic [30:0] fsbs;
      logic [30:0] mob;
      logic [30:0] kgrad;
      logic [30:0] dt;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [SUM_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] q;
   } div_rsp_type;

   typedef enum logic [2:0] {
      CSR_ALPHA = 3'd0,
      CSR_M0    = 3'd1,
      CSR_FSBS  = 3'd2,
      CSR_MOB   = 3'd3,
      CSR_KGRAD = 3'd4,
      CSR_DT    = 3'd5
   } csr_idx_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > Q_MAX) return Q_MAX[31:0];
      if (v < Q_MIN) return Q_MIN[31:0];
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + Q_RND;
      return sat32(p >>> 24);
   endfunction

endpackage

@@ rtl/core/grain_growth_phase_field_update.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - top level
// Explicit Allen-Cahn step over the grains of one quadrature point.
// ----------------------------------------------------------------------------
// Grains load at one transaction per cycle, unless stalled, into a two-bank
// store; the transaction marked last closes the run, and loading continues into
// the other bank until two closed runs wait. The update engine then emits one
// result per loaded grain and a final density result. Per run it first does
// setup (three multiplies and the density divide), then for each grain does
// store reads, shared-multiplier steps, the bit-serial divider for the
// stored-energy term and emission, and then emits the density result; with a
// zero sum of squares both divides are skipped. Results leave through an
// output register.
module grain_growth_phase_field_update #(
   parameter int MAX_GRAINS = 32,
   parameter int DIMENSIONS = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ggpf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ggpf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [30:0]       csr_wdata
);
   import ggpf_pkg::*;

   localparam int AW = $clog2(MAX_GRAINS);

   cfg_type     cfg_ff, cfg_in;
   logic        mem_wen, push, pop;
   logic [AW:0] mem_waddr, rd_addr;
   grain_type   mem_wdata, rd_data;
   run_type     push_run, head;
   logic [1:0]  run_cnt;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ALPHA: cfg_in.alpha = csr_wdata;
            CSR_M0:    cfg_in.m0    = csr_wdata;
            CSR_FSBS:  cfg_in.fsbs  = csr_wdata;
            CSR_MOB:   cfg_in.mob   = csr_wdata;
            CSR_KGRAD: cfg_in.kgrad = csr_wdata;
            CSR_DT:    cfg_in.dt    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha <= 31'd25165824;
         cfg_ff.m0    <= 31'd16777216;
         cfg_ff.fsbs  <= 31'd0;
         cfg_ff.mob   <= 31'd16777216;
         cfg_ff.kgrad <= 31'd16777216;
         cfg_ff.dt    <= 31'd167772;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ggpf_front #(.MAX_GRAINS(MAX_GRAINS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .run_cnt   (run_cnt),
      .mem_wen   (mem_wen),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .push      (push),
      .push_run  (push_run)
   );

   ggpf_store #(.MAX_GRAINS(MAX_GRAINS)) u_store (
      .clock   (clock),
      .wr_en   (mem_wen),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ggpf_runq u_runq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_run),
      .pop       (pop),
      .head      (head),
      .count     (run_cnt)
   );

   ggpf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ggpf_back #(.MAX_GRAINS(MAX_GRAINS), .DIMENSIONS(DIMENSIONS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .run_valid (run_cnt != 2'd0),
      .run       (head),
      .pop       (pop),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/ggpf_runq.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - run queue
// Two-entry queue of closed runs between the loader and the update engine.
// ----------------------------------------------------------------------------
module ggpf_runq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ggpf_pkg::run_type push_data,
   input  logic              pop,
   output ggpf_pkg::run_type head,
   output logic [1:0]        count
);
   import ggpf_pkg::*;

   run_type    ent_ff [2];
   run_type    ent_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      ent_in = ent_ff;
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         ent_in[wp_ff] = push_data;
         wp_in         = ~wp_ff;
      end
      if (pop) begin
         rp_in = ~rp_ff;
      end
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head  = ent_ff[rp_ff];
   assign count = cnt_ff;

endmodule

@@ rtl/core/ggpf_store.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - grain store
// Two banks of grain data; loader writes one bank while the engine reads.
// ----------------------------------------------------------------------------
module ggpf_store #(
   parameter int MAX_GRAINS = 32
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_GRAINS):0]     wr_addr,
   input  ggpf_pkg::grain_type             wr_data,
   input  logic [$clog2(MAX_GRAINS):0]     rd_addr,
   output ggpf_pkg::grain_type             rd_data
);
   import ggpf_pkg::*;

   localparam int DEPTH = 2 ** ($clog2(MAX_GRAINS) + 1);

   grain_type mem_ff [DEPTH];
   grain_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

@@ rtl/core/ggpf_front.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - loader
// Takes grain transactions, writes the store, sums n^2 and n^2*rho per run.
// ----------------------------------------------------------------------------
module ggpf_front #(
   parameter int MAX_GRAINS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ggpf_pkg::req_type           req_data,
   input  logic [1:0]                  run_cnt,
   output logic                        mem_wen,
   output logic [$clog2(MAX_GRAINS):0] mem_waddr,
   output ggpf_pkg::grain_type         mem_wdata,
   output logic                        push,
   output ggpf_pkg::run_type           push_run
);
   import ggpf_pkg::*;

   localparam int AW = $clog2(MAX_GRAINS);
   localparam int CW = $clog2(MAX_GRAINS + 1);

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               bank_ff, bank_in;
   logic               a_vld_ff, a_vld_in;
   logic               a_keep_ff, a_keep_in;
   logic               a_last_ff, a_last_in;
   grain_type          a_item_ff, a_item_in;
   logic [AW:0]        a_addr_ff, a_addr_in;
   logic [CW-1:0]      a_cnt_ff, a_cnt_in;
   logic signed [31:0] a_sq_ff, a_sq_in;
   logic [SUM_W-1:0]   s_ff, s_in, w_ff, w_in, s_add, w_add;
   logic signed [31:0] w_term;
   logic               accept, keep;

   // two banks: stall once both hold closed runs
   assign req_stall = ({1'b0, run_cnt} + {2'b00, a_vld_ff & a_last_ff}) >= 3'd2;
   assign accept    = req_valid & ~req_stall;
   assign keep      = cnt_ff < CW'(MAX_GRAINS);

   assign w_term = qmul(a_sq_ff, $signed({1'b0, a_item_ff.rho}));
   assign s_add  = s_ff + SUM_W'($unsigned(a_sq_ff));
   assign w_add  = w_ff + SUM_W'($unsigned(w_term));

   always_comb begin
      cnt_in    = cnt_ff;
      bank_in   = bank_ff;
      a_vld_in  = accept;
      a_keep_in = a_keep_ff;
      a_last_in = a_last_ff;
      a_item_in = a_item_ff;
      a_addr_in = a_addr_ff;
      a_cnt_in  = a_cnt_ff;
      a_sq_in   = a_sq_ff;
      s_in      = s_ff;
      w_in      = w_ff;
      if (accept) begin
         a_keep_in      = keep;
         a_last_in      = req_data.last_grain;
         a_item_in.n    = req_data.order_value;
         a_item_in.grad = {req_data.grad_z, req_data.grad_y, req_data.grad_x};
         a_item_in.rho  = req_data.grain_energy;
         a_addr_in      = {bank_ff, cnt_ff[AW-1:0]};
         a_cnt_in       = keep ? cnt_ff + CW'(1) : cnt_ff;
         a_sq_in        = qmul(req_data.order_value, req_data.order_value);
         if (req_data.last_grain) begin
            cnt_in  = '0;
            bank_in = ~bank_ff;
         end else if (keep) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
      if (a_vld_ff) begin
         if (a_last_ff) begin
            s_in = '0;
            w_in = '0;
         end else if (a_keep_ff) begin
            s_in = s_add;
            w_in = w_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_keep_ff <= a_keep_in;
      a_last_ff <= a_last_in;
      a_item_ff <= a_item_in;
      a_addr_ff <= a_addr_in;
      a_cnt_ff  <= a_cnt_in;
      a_sq_ff   <= a_sq_in;
      if (reset) begin
         cnt_ff   <= '0;
         bank_ff  <= 1'b0;
         a_vld_ff <= 1'b0;
         s_ff     <= '0;
         w_ff     <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         bank_ff  <= bank_in;
         a_vld_ff <= a_vld_in;
         s_ff     <= s_in;
         w_ff     <= w_in;
      end
   end

   assign mem_wen        = a_vld_ff & a_keep_ff;
   assign mem_waddr      = a_addr_ff;
   assign mem_wdata      = a_item_ff;
   assign push           = a_vld_ff & a_last_ff;
   assign push_run.count = IDX_W'(a_cnt_ff);
   assign push_run.s     = a_keep_ff ? s_add : s_ff;
   assign push_run.w     = a_keep_ff ? w_add : w_ff;

endmodule

@@ rtl/core/ggpf_div.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - divider
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^31.
// ----------------------------------------------------------------------------
module ggpf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ggpf_pkg::div_req_type req,
   output ggpf_pkg::div_rsp_type rsp
);
   import ggpf_pkg::*;

   logic              busy_ff, busy_in, done_ff, done_in, ovf_ff, ovf_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [QUOT_W-1:0] lo_ff, lo_in, q_ff, q_in;
   logic [SUM_W:0]    trial, diff;

   assign trial = {rem_ff, lo_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(QUOT_W);
         rem_in  = SUM_W'(req.num[NUM_W-1:QUOT_W]);
         lo_in   = req.num[QUOT_W-1:0];
         den_in  = req.den;
         ovf_in  = SUM_W'(req.num[NUM_W-1:QUOT_W]) >= req.den;
         q_in    = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[SUM_W-1:0];
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SUM_W-1:0];
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         lo_in  = {lo_ff[QUOT_W-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.q    = (ovf_ff | q_ff[QUOT_W-1]) ? {1'b1, {(QUOT_W-1){1'b0}}} : q_ff;

endmodule

@@ rtl/core/ggpf_back.sv @@
// ----------------------------------------------------------------------------
// Grain growth phase field update - update engine
// Sequences one shared multiplier and the divider over each closed run.
// ----------------------------------------------------------------------------
`include "grain_growth_phase_field_update_defines.svh"

module ggpf_back #(
   parameter int MAX_GRAINS = 32,
   parameter int DIMENSIONS = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ggpf_pkg::cfg_type           cfg,
   input  logic                        run_valid,
   input  ggpf_pkg::run_type           run,
   output logic                        pop,
   output logic [$clog2(MAX_GRAINS):0] rd_addr,
   input  ggpf_pkg::grain_type         rd_data,
   output ggpf_pkg::div_req_type       div_req,
   input  ggpf_pkg::div_rsp_type       div_rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ggpf_pkg::rsp_type           rsp_data
);
   import ggpf_pkg::*;

   localparam int AW = $clog2(MAX_GRAINS);
   localparam int CW = $clog2(MAX_GRAINS + 1);

   typedef enum logic [20:0] {
      S_IDLE  = 21'h000001,
      S_PRE1  = 21'h000002,
      S_PRE2  = 21'h000004,
      S_PRE3  = 21'h000008,
      S_RST   = 21'h000010,
      S_RDIV  = 21'h000020,
      S_RD    = 21'h000040,
      S_LOAD  = 21'h000080,
      S_SQ    = 21'h000100,
      S_FN1   = 21'h000200,
      S_A2N   = 21'h000400,
      S_FN2   = 21'h000800,
      S_FSA   = 21'h001000,
      S_FSB   = 21'h002000,
      S_FSST  = 21'h004000,
      S_FSDIV = 21'h008000,
      S_TOT   = 21'h010000,
      S_VAL   = 21'h020000,
      S_GRD   = 21'h040000,
      S_EMIT  = 21'h080000,
      S_DENS  = 21'h100000
   } state_type;

   state_type          state_ff, state_in;
   run_type            run_ff, run_in;
   logic               fault_ff, fault_in, bank_ff, bank_in, neg_ff, neg_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [1:0]         d_ff, d_in;
   logic signed [31:0] n_ff, n_in, sq_ff, sq_in, fn_ff, fn_in, t_ff, t_in;
   logic signed [31:0] fs_ff, fs_in, dtm_ff, dtm_in, dtkm_ff, dtkm_in;
   logic signed [31:0] m0fs2_ff, m0fs2_in, a2_ff, a2_in, ssat_ff, ssat_in;
   logic signed [31:0] rhoc_ff, rhoc_in, val_ff, val_in;
   logic [30:0]        rho_ff, rho_in;
   logic [2:0][31:0]   g_ff, g_in, go_ff, go_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_type            rsp_ff, rsp_in;
   logic signed [31:0] ma, mb, mr, m02;
   logic [31:0]        tmag;
   logic               out_free;

   assign m02      = cfg.m0[30] ? Q_MAX[31:0] : {cfg.m0, 1'b0};
   assign out_free = ~rsp_vld_ff | ~rsp_stall;
   assign tmag     = t_ff[31] ? 32'(-t_ff) : t_ff;
   assign mr       = qmul(ma, mb);

   always_comb begin
      unique case (state_ff)
         S_PRE1: begin
            ma = $signed({1'b0, cfg.dt});
            mb = $signed({1'b0, cfg.mob});
         end
         S_PRE2: begin
            ma = dtm_ff;
            mb = $signed({1'b0, cfg.kgrad});
         end
         S_PRE3: begin
            ma = m02;
            mb = $signed({1'b0, cfg.fsbs});
         end
         S_FN1: begin
            ma = sq_ff;
            mb = n_ff;
         end
         S_A2N: begin
            ma = a2_ff;
            mb = n_ff;
         end
         S_FN2: begin
            ma = t_ff;
            mb = sat32(64'(ssat_ff) - 64'(sq_ff));
         end
         S_FSA: begin
            ma = m0fs2_ff;
            mb = n_ff;
         end
         S_FSB: begin
            ma = t_ff;
            mb = sat32(64'($signed({1'b0, rho_ff})) - 64'(rhoc_ff));
         end
         S_TOT: begin
            ma = $signed({1'b0, cfg.m0});
            mb = fn_ff;
         end
         S_VAL: begin
            ma = dtm_ff;
            mb = t_ff;
         end
         S_GRD: begin
            ma = dtkm_ff;
            mb = $signed(g_ff[d_ff]);
         end
         default: begin
            ma = n_ff;
            mb = n_ff;
         end
      endcase
   end

   always_comb begin
      div_req.start = (state_ff == S_RST) | (state_ff == S_FSST);
      div_req.den   = run_ff.s;
      if (state_ff == S_RST) begin
         div_req.num = {run_ff.w, 24'd0};
      end else begin
         div_req.num = NUM_W'({tmag, 24'd0});
      end
   end

   always_comb begin
      state_in   = state_ff;
      run_in     = run_ff;
      fault_in   = fault_ff;
      bank_in    = bank_ff;
      neg_in     = neg_ff;
      idx_in     = idx_ff;
      d_in       = d_ff;
      n_in       = n_ff;
      sq_in      = sq_ff;
      fn_in      = fn_ff;
      t_in       = t_ff;
      fs_in      = fs_ff;
      dtm_in     = dtm_ff;
      dtkm_in    = dtkm_ff;
      m0fs2_in   = m0fs2_ff;
      a2_in      = a2_ff;
      ssat_in    = ssat_ff;
      rhoc_in    = rhoc_ff;
      val_in     = val_ff;
      rho_in     = rho_ff;
      g_in       = g_ff;
      go_in      = go_ff;
      rsp_vld_in = rsp_vld_ff & rsp_stall;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (run_valid) begin
               run_in   = run;
               fault_in = (run.s == '0);
               ssat_in  = (run.s > SUM_W'(Q_MAX)) ? Q_MAX[31:0] : run.s[31:0];
               a2_in    = cfg.alpha[30] ? Q_MAX[31:0] : {cfg.alpha, 1'b0};
               rhoc_in  = '0;
               idx_in   = '0;
               state_in = S_PRE1;
            end
         end
         S_PRE1: begin
            dtm_in   = mr;
            state_in = S_PRE2;
         end
         S_PRE2: begin
            dtkm_in  = mr;
            state_in = S_PRE3;
         end
         S_PRE3: begin
            m0fs2_in = mr;
            state_in = fault_ff ? S_RD : S_RST;
         end
         S_RST: begin
            state_in = S_RDIV;
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               rhoc_in  = div_rsp.q[31] ? Q_MAX[31:0] : div_rsp.q;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            n_in     = rd_data.n;
            rho_in   = rd_data.rho;
            g_in     = rd_data.grad;
            fs_in    = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            sq_in    = mr;
            state_in = S_FN1;
         end
         S_FN1: begin
            fn_in    = sat32(64'(mr) - 64'(n_ff));
            state_in = S_A2N;
         end
         S_A2N: begin
            t_in     = mr;
            state_in = S_FN2;
         end
         S_FN2: begin
            fn_in    = sat32(64'(fn_ff) + 64'(mr));
            state_in = S_FSA;
         end
         S_FSA: begin
            t_in     = mr;
            state_in = S_FSB;
         end
         S_FSB: begin
            t_in     = mr;
            state_in = fault_ff ? S_TOT : S_FSST;
         end
         S_FSST: begin
            neg_in   = t_ff[31];
            state_in = S_FSDIV;
         end
         S_FSDIV: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  fs_in = 32'(-div_rsp.q);
               end else begin
                  fs_in = div_rsp.q[31] ? Q_MAX[31:0] : div_rsp.q;
               end
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            t_in     = sat32(64'(mr) + 64'(fs_ff));
            state_in = S_VAL;
         end
         S_VAL: begin
            val_in   = sat32(64'(n_ff) - 64'(mr));
            go_in    = '0;
            d_in     = '0;
            state_in = S_GRD;
         end
         S_GRD: begin
            go_in[d_ff] = sat32(-64'(mr));
            if (d_ff == 2'(DIMENSIONS - 1)) begin
               state_in = S_EMIT;
            end else begin
               d_in = d_ff + 2'd1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.term_kind    = 1'b0;
               rsp_in.grain_index  = IDX_W'(idx_ff);
               rsp_in.value_term   = val_ff;
               rsp_in.out_grad_x   = go_ff[0];
               rsp_in.out_grad_y   = go_ff[1];
               rsp_in.out_grad_z   = go_ff[2];
               rsp_in.divide_fault = fault_ff;
               rsp_in.last_result  = 1'b0;
               idx_in              = idx_ff + CW'(1);
               if ((IDX_W'(idx_ff) + IDX_W'(1)) == run_ff.count) begin
                  state_in = S_DENS;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_DENS: begin
            if (out_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.term_kind    = 1'b1;
               rsp_in.grain_index  = run_ff.count;
               rsp_in.value_term   = rhoc_ff;
               rsp_in.out_grad_x   = '0;
               rsp_in.out_grad_y   = '0;
               rsp_in.out_grad_z   = '0;
               rsp_in.divide_fault = fault_ff;
               rsp_in.last_result  = 1'b1;
               pop                 = 1'b1;
               bank_in             = ~bank_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      fault_ff <= fault_in;
      neg_ff   <= neg_in;
      idx_ff   <= idx_in;
      d_ff     <= d_in;
      n_ff     <= n_in;
      sq_ff    <= sq_in;
      fn_ff    <= fn_in;
      t_ff     <= t_in;
      fs_ff    <= fs_in;
      dtm_ff   <= dtm_in;
      dtkm_ff  <= dtkm_in;
      m0fs2_ff <= m0fs2_in;
      a2_ff    <= a2_in;
      ssat_ff  <= ssat_in;
      rhoc_ff  <= rhoc_in;
      val_ff   <= val_in;
      rho_ff   <= rho_in;
      g_ff     <= g_in;
      go_ff    <= go_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         bank_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bank_ff    <= bank_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rd_addr   = {bank_ff, idx_ff[AW-1:0]};
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `GGPF_ASSERT_NOW(a_fault_no_div, clock, reset, fault_ff && (state_ff != S_IDLE), !div_req.start, "divide started on a zero-sum run")
   `GGPF_ASSERT_NEXT(a_div_wait, clock, reset, state_ff == S_FSST, state_ff == S_FSDIV, "divide start not followed by wait")
   `GGPF_ASSERT_NOW(a_idx_range, clock, reset, state_ff == S_LOAD, IDX_W'(idx_ff) < run_ff.count, "grain read beyond run")
   `GGPF_ASSERT_NEXT(a_emit_hold, clock, reset, (state_ff == S_EMIT) && rsp_vld_ff && rsp_stall, state_ff == S_EMIT, "result overwrote a stalled transaction")

endmodule
